@@ design/qvr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths and types shared by the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int VEC_W  = 24;
  localparam int ROT_W  = 16;
  localparam int FRAC_W = 30;

  // First product q * v: one term and the sum of three terms.
  localparam int P1_W = VEC_W + ROT_W;
  localparam int T_W  = P1_W + 2;

  // Second product t * conj(q): one term and the sum of four terms.
  localparam int P2_W = T_W + ROT_W;
  localparam int R_W  = P2_W + 2;

  localparam int RND_W = R_W - FRAC_W;

  localparam int IN_DATA_W  = 3 * VEC_W + 4 * ROT_W;
  localparam int OUT_DATA_W = 3 * VEC_W;

  typedef struct packed {
    logic signed [VEC_W-1:0] value;
    logic                    sat;
  } comp_t;

endpackage
`default_nettype wire

@@ design/quaternion_vector_rotate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a 3-vector by a quaternion as q * (v,0) * conj(q), fixed point.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while the output side is not stalled
// and returns one result per request. The path has five register stages:
// first products, first sums, second products, second sums, and rounding with
// saturation into the output register. The quaternion is not normalized, so
// the result is the rotated vector scaled by |q|^2; saturation of any
// component raises out_tuser.
module quaternion_vector_rotate (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // vec_x, vec_y, vec_z (24 bits each), rot_x, rot_y, rot_z, rot_w (16 bits)
  input  wire logic [qvr_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_x, out_y, out_z (24 bits each)
  output logic [qvr_pkg::OUT_DATA_W-1:0]        out_tdata,
  // saturated
  output logic                                  out_tuser
);

  localparam int VW = qvr_pkg::VEC_W;
  localparam int RW = qvr_pkg::ROT_W;

  logic signed [VW-1:0] vx, vy, vz;
  logic signed [RW-1:0] qx, qy, qz, qw;

  assign vx = in_tdata[VW-1:0];
  assign vy = in_tdata[2*VW-1:VW];
  assign vz = in_tdata[3*VW-1:2*VW];
  assign qx = in_tdata[3*VW+RW-1:3*VW];
  assign qy = in_tdata[3*VW+2*RW-1:3*VW+RW];
  assign qz = in_tdata[3*VW+3*RW-1:3*VW+2*RW];
  assign qw = in_tdata[3*VW+4*RW-1:3*VW+3*RW];

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5      = !v5_r || out_tready;
  assign adv4      = !v4_r || adv5;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // Stage 1: the twelve products of q * (v,0).
  logic signed [qvr_pkg::P1_W-1:0] p1_r [12];
  logic signed [RW-1:0] q1x_r, q1y_r, q1z_r, q1w_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      p1_r[0]  <= qy * vz;
      p1_r[1]  <= qz * vy;
      p1_r[2]  <= qw * vx;
      p1_r[3]  <= qz * vx;
      p1_r[4]  <= qx * vz;
      p1_r[5]  <= qw * vy;
      p1_r[6]  <= qx * vy;
      p1_r[7]  <= qy * vx;
      p1_r[8]  <= qw * vz;
      p1_r[9]  <= qx * vx;
      p1_r[10] <= qy * vy;
      p1_r[11] <= qz * vz;
      q1x_r    <= qx;
      q1y_r    <= qy;
      q1z_r    <= qz;
      q1w_r    <= qw;
    end
  end

  // Stage 2: t = q * (v,0).
  logic signed [qvr_pkg::T_W-1:0] tx_r, ty_r, tz_r, tw_r;
  logic signed [RW-1:0] q2x_r, q2y_r, q2z_r, q2w_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      tx_r  <= qvr_pkg::T_W'(p1_r[0]) - qvr_pkg::T_W'(p1_r[1]) + qvr_pkg::T_W'(p1_r[2]);
      ty_r  <= qvr_pkg::T_W'(p1_r[3]) - qvr_pkg::T_W'(p1_r[4]) + qvr_pkg::T_W'(p1_r[5]);
      tz_r  <= qvr_pkg::T_W'(p1_r[6]) - qvr_pkg::T_W'(p1_r[7]) + qvr_pkg::T_W'(p1_r[8]);
      tw_r  <= -(qvr_pkg::T_W'(p1_r[9]) + qvr_pkg::T_W'(p1_r[10]) +
                 qvr_pkg::T_W'(p1_r[11]));
      q2x_r <= q1x_r;
      q2y_r <= q1y_r;
      q2z_r <= q1z_r;
      q2w_r <= q1w_r;
    end
  end

  // Stage 3: the twelve products of t * conj(q).
  logic signed [qvr_pkg::P2_W-1:0] p2_r [12];

  always_ff @(posedge clk) begin
    if (adv3) begin
      p2_r[0]  <= ty_r * q2z_r;
      p2_r[1]  <= tz_r * q2y_r;
      p2_r[2]  <= tx_r * q2w_r;
      p2_r[3]  <= tw_r * q2x_r;
      p2_r[4]  <= tz_r * q2x_r;
      p2_r[5]  <= tx_r * q2z_r;
      p2_r[6]  <= ty_r * q2w_r;
      p2_r[7]  <= tw_r * q2y_r;
      p2_r[8]  <= tx_r * q2y_r;
      p2_r[9]  <= ty_r * q2x_r;
      p2_r[10] <= tz_r * q2w_r;
      p2_r[11] <= tw_r * q2z_r;
    end
  end

  // Stage 4: vector part of t * conj(q).
  logic signed [qvr_pkg::R_W-1:0] rx_r, ry_r, rz_r;

  always_ff @(posedge clk) begin
    if (adv4) begin
      rx_r <= qvr_pkg::R_W'(p2_r[1]) + qvr_pkg::R_W'(p2_r[2]) -
              qvr_pkg::R_W'(p2_r[0]) - qvr_pkg::R_W'(p2_r[3]);
      ry_r <= qvr_pkg::R_W'(p2_r[5]) + qvr_pkg::R_W'(p2_r[6]) -
              qvr_pkg::R_W'(p2_r[4]) - qvr_pkg::R_W'(p2_r[7]);
      rz_r <= qvr_pkg::R_W'(p2_r[9]) + qvr_pkg::R_W'(p2_r[10]) -
              qvr_pkg::R_W'(p2_r[8]) - qvr_pkg::R_W'(p2_r[11]);
    end
  end

  // Stage 5: rounding, saturation and the output register.
  qvr_pkg::comp_t cx, cy, cz;

  qvr_round_sat u_rs_x (.sum_i(rx_r), .comp_o(cx));
  qvr_round_sat u_rs_y (.sum_i(ry_r), .comp_o(cy));
  qvr_round_sat u_rs_z (.sum_i(rz_r), .comp_o(cz));

  logic [qvr_pkg::OUT_DATA_W-1:0] odata_r;
  logic                           osat_r;

  always_ff @(posedge clk) begin
    if (adv5) begin
      odata_r <= {cz.value, cy.value, cx.value};
      osat_r  <= cx.sat | cy.sat | cz.sat;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = osat_r;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !adv4 |=> v3_r && $stable(p2_r[0]))
    else $error("stalled third stage lost its item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !out_tready |=> v5_r && $stable(odata_r))
    else $error("pending result was overwritten");

  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      odata_r[VW-2:0] == {(VW-1){~odata_r[VW-1]}} ||
      odata_r[2*VW-2:VW] == {(VW-1){~odata_r[2*VW-1]}} ||
      odata_r[3*VW-2:2*VW] == {(VW-1){~odata_r[3*VW-1]}})
    else $error("saturation flagged but no component is at a rail");
`endif

endmodule
`default_nettype wire

@@ design/qvr_round_sat.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_round_sat
// Scales one exact sum by 2^-30 with round to nearest (ties up) and
// saturates it to a signed vector component.
// ----------------------------------------------------------------------------
module qvr_round_sat (
  input  wire logic signed [qvr_pkg::R_W-1:0] sum_i,
  output qvr_pkg::comp_t                      comp_o
);

  logic signed [qvr_pkg::R_W-1:0]   biased;
  logic        [qvr_pkg::RND_W-1:0] rnd;
  logic                             ovf;

  assign biased = sum_i + $signed({{(qvr_pkg::R_W - qvr_pkg::FRAC_W){1'b0}}, 1'b1,
                                   {(qvr_pkg::FRAC_W - 1){1'b0}}});
  assign rnd    = biased[qvr_pkg::R_W-1:qvr_pkg::FRAC_W];
  assign ovf    = ~(&rnd[qvr_pkg::RND_W-1:qvr_pkg::VEC_W-1]) &
                  (|rnd[qvr_pkg::RND_W-1:qvr_pkg::VEC_W-1]);

  always_comb begin
    comp_o.sat = ovf;
    if (!ovf) begin
      comp_o.value = rnd[qvr_pkg::VEC_W-1:0];
    end else if (rnd[qvr_pkg::RND_W-1]) begin
      comp_o.value = {1'b1, {(qvr_pkg::VEC_W - 1){1'b0}}};
    end else begin
      comp_o.value = {1'b0, {(qvr_pkg::VEC_W - 1){1'b1}}};
    end
  end

endmodule
`default_nettype wire
